>>> hdl/mi3_pkg.sv
// Package: types, constants and step functions for the 3x3 matrix inverse pipeline.
`default_nettype none

package mi3_pkg;

   // element and intermediate widths
   localparam int EW    = 32;   // Q16.16 element
   localparam int PW    = 64;   // Q32.32 product / cofactor
   localparam int DETW  = 98;   // signed Q48.48 determinant
   localparam int DW    = 97;   // determinant magnitude and divider remainder
   localparam int TW    = 63;   // threshold register
   localparam int NEL   = 9;
   localparam int NDIV  = 32;   // quotient bits, one per divider stage
   localparam int NPRE  = 7;    // stages ahead of the divider
   localparam int NST   = NPRE + NDIV;

   localparam logic [TW-1:0] THR_RESET = TW'(281);

   // adjugate entry k = m[A]*m[B] - m[C]*m[D], entries in row order
   localparam int CF_A [NEL] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int CF_B [NEL] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int CF_C [NEL] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int CF_D [NEL] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   typedef logic signed [EW-1:0] elem_type;
   typedef logic signed [PW-1:0] prod_type;

   // one divider stage: nine lanes sharing the divisor
   typedef struct packed {
      logic [DW-1:0]           dvs;
      logic                    sing;
      logic [NEL-1:0]          neg;
      logic [NEL-1:0]          ovf;
      logic [NEL-1:0][DW-1:0]  rem;
      logic [NEL-1:0][EW-1:0]  quo;
   } div_type;

   // one restoring step on every lane
   function automatic div_type div_step(div_type x);
      div_type    y;
      logic [DW:0] r2;
      y = x;
      for (int k = 0; k < NEL; k++) begin
         r2 = {x.rem[k], 1'b0};
         if (r2 >= {1'b0, x.dvs}) begin
            y.rem[k] = DW'(r2 - {1'b0, x.dvs});
            y.quo[k] = {x.quo[k][EW-2:0], 1'b1};
         end else begin
            y.rem[k] = r2[DW-1:0];
            y.quo[k] = {x.quo[k][EW-2:0], 1'b0};
         end
      end
      return y;
   endfunction

   // round to nearest, apply sign and saturate one lane
   function automatic logic [EW-1:0] finish_lane(logic [DW-1:0] rem, logic [EW-1:0] quo,
                                                 logic [DW-1:0] dvs, logic neg, logic ovf);
      logic        rnd;
      logic [EW:0] qr;
      logic [EW-1:0] res;
      rnd = {rem, 1'b0} >= {1'b0, dvs};
      qr  = {1'b0, quo} + (EW+1)'(rnd);
      if (neg) begin
         if (ovf || qr > (EW+1)'(33'h080000000)) res = 32'h80000000;
         else res = EW'(-qr);
      end else begin
         if (ovf || qr > (EW+1)'(33'h07FFFFFFF)) res = 32'h7FFFFFFF;
         else res = qr[EW-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> hdl/matrix_inverse3x3.sv
// Top level: pipelined 3x3 matrix inverse by adjugate and restoring division.
//
//  channel   direction  handshake              payload
//  req_      in         req_valid/req_ready    req_in_r0c0 .. req_in_r2c2 (Q16.16)
//  rsp_      out        rsp_valid/rsp_ready    rsp_inv_r0c0 .. rsp_inv_r2c2, rsp_invertible
//  csr_      in         csr_valid/csr_ready    csr_wdata (singular threshold, 2^-48 units)
//
// One request enters per cycle while req_ready is high; acceptance leads to rsp_valid through
// seven stages for products, cofactors, determinant, magnitudes and divider setup, 32 divider stages
// (one quotient bit each, nine lanes in parallel), then the rounding/output register.
// Reset clears all valid bits and loads the threshold with 281; csr_ready is always high.
// Each stage holds only while it is full and the stage after it is blocked, so bubbles
// collapse and a stalled output does not block intake until the pipeline fills.
`default_nettype none

module matrix_inverse3x3
   import mi3_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic signed [31:0]   req_in_r0c0,
   input  wire logic signed [31:0]   req_in_r0c1,
   input  wire logic signed [31:0]   req_in_r0c2,
   input  wire logic signed [31:0]   req_in_r1c0,
   input  wire logic signed [31:0]   req_in_r1c1,
   input  wire logic signed [31:0]   req_in_r1c2,
   input  wire logic signed [31:0]   req_in_r2c0,
   input  wire logic signed [31:0]   req_in_r2c1,
   input  wire logic signed [31:0]   req_in_r2c2,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic signed [31:0]        rsp_inv_r0c0,
   output logic signed [31:0]        rsp_inv_r0c1,
   output logic signed [31:0]        rsp_inv_r0c2,
   output logic signed [31:0]        rsp_inv_r1c0,
   output logic signed [31:0]        rsp_inv_r1c1,
   output logic signed [31:0]        rsp_inv_r1c2,
   output logic signed [31:0]        rsp_inv_r2c0,
   output logic signed [31:0]        rsp_inv_r2c1,
   output logic signed [31:0]        rsp_inv_r2c2,
   output logic                      rsp_invertible,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [62:0]          csr_wdata
);

   elem_type m [NEL];

   logic [TW-1:0]  thr_ff;
   logic           vld_ff [NST];
   logic           vld_in [NST];
   logic           rdy    [NST];
   logic           out_rdy;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   // stage payloads
   prod_type                  prod_ff  [2*NEL];
   elem_type                  row1_ff  [3];
   prod_type                  adj2_ff  [NEL];
   elem_type                  row2_ff  [3];
   logic signed [PW-1:0]      ph_ff    [3];
   logic signed [PW:0]        pl_ff    [3];
   prod_type                  adj3_ff  [NEL];
   logic signed [DETW-1:0]    term_ff  [3];
   prod_type                  adj4_ff  [NEL];
   logic signed [DETW-1:0]    det_ff;
   prod_type                  adj5_ff  [NEL];
   logic                      dneg_ff;
   logic [DW-1:0]             dmag_ff;
   logic [PW-1:0]             amag_ff  [NEL];
   logic [NEL-1:0]            asgn_ff;
   div_type                   pre_ff;
   div_type                   div_ff   [NDIV];
   logic [NEL-1:0][EW-1:0]    res_ff;
   logic                      inv_ff;

   assign m[0] = req_in_r0c0;
   assign m[1] = req_in_r0c1;
   assign m[2] = req_in_r0c2;
   assign m[3] = req_in_r1c0;
   assign m[4] = req_in_r1c1;
   assign m[5] = req_in_r1c2;
   assign m[6] = req_in_r2c0;
   assign m[7] = req_in_r2c1;
   assign m[8] = req_in_r2c2;

   // take threshold writes at any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_wdata;
      end
   end

   // advance each stage when it is empty or its successor moves
   assign out_rdy = !rsp_valid_ff || rsp_ready;
   assign rdy[NST-1] = !vld_ff[NST-1] || out_rdy;
   for (genvar s = 0; s < NST - 1; s++) begin : g_rdy
      assign rdy[s] = !vld_ff[s] || rdy[s+1];
   end
   assign req_ready = rdy[0];

   always_comb begin
      vld_in[0] = rdy[0] ? req_valid : vld_ff[0];
      for (int s = 1; s < NST; s++) begin
         vld_in[s] = rdy[s] ? vld_ff[s-1] : vld_ff[s];
      end
      rsp_valid_in = out_rdy ? vld_ff[NST-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) begin
            vld_ff[s] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int s = 0; s < NST; s++) begin
            vld_ff[s] <= vld_in[s];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage 1: the eighteen 2x2 minor products
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         for (int k = 0; k < NEL; k++) begin
            prod_ff[2*k]   <= PW'(m[CF_A[k]]) * PW'(m[CF_B[k]]);
            prod_ff[2*k+1] <= PW'(m[CF_C[k]]) * PW'(m[CF_D[k]]);
         end
         for (int j = 0; j < 3; j++) begin
            row1_ff[j] <= m[j];
         end
      end
   end

   // stage 2: cofactors
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         for (int k = 0; k < NEL; k++) begin
            adj2_ff[k] <= prod_ff[2*k] - prod_ff[2*k+1];
         end
         row2_ff <= row1_ff;
      end
   end

   // stage 3: row 0 times cofactor, split into high and low halves
   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         for (int j = 0; j < 3; j++) begin
            ph_ff[j] <= PW'(row2_ff[j]) * PW'($signed(adj2_ff[3*j][PW-1:32]));
            pl_ff[j] <= (PW+1)'(row2_ff[j]) * $signed({1'b0, adj2_ff[3*j][31:0]});
         end
         adj3_ff <= adj2_ff;
      end
   end

   // stage 4: recombine halves
   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         for (int j = 0; j < 3; j++) begin
            term_ff[j] <= (DETW'(ph_ff[j]) <<< 32) + DETW'(pl_ff[j]);
         end
         adj4_ff <= adj3_ff;
      end
   end

   // stage 5: determinant
   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         det_ff  <= term_ff[0] + term_ff[1] + term_ff[2];
         adj5_ff <= adj4_ff;
      end
   end

   // stage 6: magnitudes and signs
   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         dneg_ff <= det_ff[DETW-1];
         dmag_ff <= det_ff[DETW-1] ? DW'(-det_ff) : DW'(det_ff);
         for (int k = 0; k < NEL; k++) begin
            asgn_ff[k] <= adj5_ff[k][PW-1];
            amag_ff[k] <= adj5_ff[k][PW-1] ? PW'(-adj5_ff[k]) : PW'(adj5_ff[k]);
         end
      end
   end

   // stage 7: singular test, overflow test, divider setup
   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         pre_ff.dvs  <= dmag_ff;
         pre_ff.sing <= (dmag_ff == '0) || (dmag_ff < DW'(thr_ff));
         for (int k = 0; k < NEL; k++) begin
            pre_ff.neg[k] <= asgn_ff[k] ^ dneg_ff;
            pre_ff.ovf[k] <= DW'(amag_ff[k]) >= dmag_ff;
            pre_ff.rem[k] <= DW'(amag_ff[k]);
            pre_ff.quo[k] <= '0;
         end
      end
   end

   // divider: one quotient bit per stage
   for (genvar d = 0; d < NDIV; d++) begin : g_div
      div_type src;
      if (d == 0) begin : g_first
         assign src = pre_ff;
      end else begin : g_next
         assign src = div_ff[d-1];
      end
      always_ff @(posedge clock) begin
         if (rdy[NPRE+d]) begin
            div_ff[d] <= div_step(src);
         end
      end
   end

   // output register: round, saturate, zero when singular
   always_ff @(posedge clock) begin
      if (out_rdy) begin
         inv_ff <= !div_ff[NDIV-1].sing;
         for (int k = 0; k < NEL; k++) begin
            res_ff[k] <= div_ff[NDIV-1].sing ? '0 :
                         finish_lane(div_ff[NDIV-1].rem[k], div_ff[NDIV-1].quo[k],
                                     div_ff[NDIV-1].dvs, div_ff[NDIV-1].neg[k],
                                     div_ff[NDIV-1].ovf[k]);
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_invertible = inv_ff;
   assign rsp_inv_r0c0   = res_ff[0];
   assign rsp_inv_r0c1   = res_ff[1];
   assign rsp_inv_r0c2   = res_ff[2];
   assign rsp_inv_r1c0   = res_ff[3];
   assign rsp_inv_r1c1   = res_ff[4];
   assign rsp_inv_r1c2   = res_ff[5];
   assign rsp_inv_r2c0   = res_ff[6];
   assign rsp_inv_r2c1   = res_ff[7];
   assign rsp_inv_r2c2   = res_ff[8];

   // a singular result carries all-zero elements
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !inv_ff |-> res_ff == '0)
      else $error("singular result with nonzero elements");

   // an empty output register never blocks intake
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("intake stalled with empty output");

   // a nonsingular item reaches the divider with a nonzero divisor
   a_dvs_nonzero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NPRE-1] && !pre_ff.sing |-> pre_ff.dvs != '0)
      else $error("zero divisor passed singular test");

   // a held last pipeline stage keeps its valid bit
   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NST-1] && !rdy[NST-1] |=> vld_ff[NST-1])
      else $error("stalled last stage lost its request");

endmodule

`default_nettype wire
